[hw/rtl/spi_as_pkg.sv]
`default_nettype none
package spi_as_pkg;

  localparam int unsigned WordW = 5;
  localparam int unsigned PacketW = 20;
  localparam int unsigned DataW = 16;
  localparam int unsigned CrcW = 4;
  localparam int unsigned CountW = 3;

  localparam logic [PacketW-1:0] PacketOnes = 20'hFFFFF;
  localparam logic [CrcW-1:0] CrcSeed = 4'hF;
  localparam logic [CrcW-1:0] CrcPoly = 4'h3;
  localparam logic [DataW-1:0] FieldReset = 16'd380;
  localparam logic [11:0] TempMax = 12'hFFF;
  localparam logic [CountW-1:0] WordsPerPacket = 3'd4;
  localparam logic [CountW-1:0] CountSat = 3'd5;

  typedef enum logic [1:0] {
    REQ_CS_FALL = 2'd0,
    REQ_CS_RISE = 2'd1,
    REQ_XFER    = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  typedef enum logic [5:0] {
    REG_ANGLE = 6'h20,
    REG_TEMP  = 6'h28,
    REG_FIELD = 6'h2A
  } reg_addr_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [WordW-1:0]  word_in;
    logic              powered;
    logic [11:0]       shaft_angle;
    logic signed [15:0] temp_eighths;
  } item_t;

  function automatic logic [CrcW-1:0] crc4(input logic [DataW-1:0] data);
    logic [CrcW-1:0] crc;
    logic fb;
    crc = CrcSeed;
    for (int i = DataW - 1; i >= 0; i--) begin
      fb = crc[CrcW-1] ^ data[i];
      crc = {crc[CrcW-2:0], 1'b0} ^ (fb ? CrcPoly : '0);
    end
    return crc;
  endfunction

  function automatic logic [DataW-1:0] clamp_temp(input logic signed [15:0] t);
    logic [DataW-1:0] v;
    if (t[15]) begin
      v = '0;
    end else if (|t[14:12]) begin
      v = {4'd0, TempMax};
    end else begin
      v = {4'd0, t[11:0]};
    end
    return v;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/spi_as_in_reg.sv]
`default_nettype none
module spi_as_in_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire logic              advance,
  input  wire spi_as_pkg::item_t item_in,
  output logic                   valid,
  output spi_as_pkg::item_t      item_out
);

  logic              valid_r, valid_nxt;
  spi_as_pkg::item_t item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_in;
    end
  end

  assign valid    = valid_r;
  assign item_out = item_r;

endmodule
`default_nettype wire

[hw/rtl/spi_as_core.sv]
`default_nettype none
module spi_as_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [spi_as_pkg::DataW-1:0]       cfg_wr_data,
  input  wire logic                               fire,
  input  wire spi_as_pkg::item_t                  item,
  output logic                                    is_xfer,
  output logic [spi_as_pkg::WordW-1:0]            word_out
);

  logic [spi_as_pkg::DataW-1:0]   field_r;
  logic [spi_as_pkg::CountW-1:0]  word_count_r, word_count_nxt;
  logic [spi_as_pkg::PacketW-1:0] cmd_r, cmd_nxt;
  logic [spi_as_pkg::PacketW-1:0] reply_r, reply_nxt;

  logic [spi_as_pkg::PacketW-1:0] reply_src;
  logic [1:0]                     at;
  logic [spi_as_pkg::DataW-1:0]   rd_data;
  logic [5:0]                     reg_addr;

  assign is_xfer  = (item.req_type == spi_as_pkg::REQ_XFER);
  assign reg_addr = cmd_r[17:12];

  always_comb begin
    case (reg_addr)
      spi_as_pkg::REG_ANGLE: rd_data = {4'd0, item.shaft_angle};
      spi_as_pkg::REG_TEMP:  rd_data = spi_as_pkg::clamp_temp(item.temp_eighths);
      spi_as_pkg::REG_FIELD: rd_data = field_r;
      default:               rd_data = '0;
    endcase
  end

  always_comb begin
    reply_src = item.powered ? reply_r : spi_as_pkg::PacketOnes;
    at = (word_count_r < spi_as_pkg::WordsPerPacket) ? word_count_r[1:0] : 2'd3;
    case (at)
      2'd0:    word_out = reply_src[19:15];
      2'd1:    word_out = reply_src[14:10];
      2'd2:    word_out = reply_src[9:5];
      default: word_out = reply_src[4:0];
    endcase
  end

  always_comb begin
    word_count_nxt = word_count_r;
    cmd_nxt        = cmd_r;
    reply_nxt      = reply_r;
    case (item.req_type)
      spi_as_pkg::REQ_CS_FALL: begin
        word_count_nxt = '0;
        cmd_nxt        = '0;
      end
      spi_as_pkg::REQ_CS_RISE: begin
        if (word_count_r == spi_as_pkg::WordsPerPacket) begin
          if (cmd_r[18] || !item.powered) begin
            reply_nxt = spi_as_pkg::PacketOnes;
          end else begin
            reply_nxt = {rd_data, spi_as_pkg::crc4(rd_data)};
          end
        end
        word_count_nxt = '0;
      end
      spi_as_pkg::REQ_XFER: begin
        cmd_nxt = {cmd_r[spi_as_pkg::PacketW-spi_as_pkg::WordW-1:0], item.word_in};
        if (word_count_r < spi_as_pkg::CountSat) begin
          word_count_nxt = word_count_r + 3'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_r      <= spi_as_pkg::FieldReset;
      word_count_r <= '0;
      cmd_r        <= '0;
      reply_r      <= spi_as_pkg::PacketOnes;
    end else begin
      if (cfg_wr_en) begin
        field_r <= cfg_wr_data;
      end
      if (fire) begin
        word_count_r <= word_count_nxt;
        cmd_r        <= cmd_nxt;
        reply_r      <= reply_nxt;
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/spi_as_out_reg.sv]
`default_nettype none
module spi_as_out_reg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  input  wire logic [spi_as_pkg::WordW-1:0]  word_in,
  input  wire logic                          stall,
  output logic                               valid,
  output logic [spi_as_pkg::WordW-1:0]       word_out
);

  logic                         valid_r, valid_nxt;
  logic [spi_as_pkg::WordW-1:0] word_r;

  always_comb begin
    valid_nxt = valid_r;
    if (push) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      word_r <= word_in;
    end
  end

  assign valid    = valid_r;
  assign word_out = word_r;

endmodule
`default_nettype wire

[hw/rtl/spi_angle_sensor_register_slave_unit.sv]
// SPI register slave of a magnetic angle sensor, driven by decoded bus events.
// Input channel: in_valid/in_stall carry one event per item: chip select fall,
// chip select rise, or a 5-bit word transfer with the sensor's live readings.
// Output channel: out_valid/out_stall carry one 5-bit reply word for each
// transfer item; select edges produce no output item.
// The configuration port writes the field strength register whenever
// cfg_wr_en is high; it should be written only while no item is in flight.
// An accepted item is registered in the input register, processed by the
// decode and CRC logic, and its reply word is registered in the output
// register, which drives out_valid.
// Throughput: one item per cycle without stalls, set by the single input
// register and the single output register with the state update in between.
// When the receiver stalls, the reply stays in the output register and the
// next transfer item waits in the input register; select edges still pass.
// Reset clears the word count and command, sets the reply to all ones and
// the field strength to 380, and empties both registers.
`default_nettype none
module spi_angle_sensor_register_slave_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [1:0]                         in_req_type,
  input  wire logic [spi_as_pkg::WordW-1:0]       in_word_in,
  input  wire logic                               in_powered,
  input  wire logic [11:0]                        in_shaft_angle,
  input  wire logic signed [15:0]                 in_temp_eighths,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [spi_as_pkg::WordW-1:0]            out_word_out,
  input  wire logic                               cfg_wr_en,
  input  wire logic [spi_as_pkg::DataW-1:0]       cfg_wr_data
);

  spi_as_pkg::item_t             item_in, item_q;
  logic                          q_valid;
  logic                          advance;
  logic                          load;
  logic                          is_xfer;
  logic [spi_as_pkg::WordW-1:0]  reply_word;

  assign item_in = '{req_type:     in_req_type,
                     word_in:      in_word_in,
                     powered:      in_powered,
                     shaft_angle:  in_shaft_angle,
                     temp_eighths: in_temp_eighths};

  assign advance  = q_valid && (!is_xfer || !out_valid || !out_stall);
  assign in_stall = q_valid && !advance;
  assign load     = in_valid && !in_stall;

  spi_as_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load),
    .advance  (advance),
    .item_in  (item_in),
    .valid    (q_valid),
    .item_out (item_q)
  );

  spi_as_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (advance),
    .item        (item_q),
    .is_xfer     (is_xfer),
    .word_out    (reply_word)
  );

  spi_as_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (advance && is_xfer),
    .word_in  (reply_word),
    .stall    (out_stall),
    .valid    (out_valid),
    .word_out (out_word_out)
  );

  a_xfer_gives_output: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && is_xfer) |=> out_valid)
    else $error("transfer item produced no output");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && !out_valid) |-> !in_stall)
    else $error("input stalled with empty output register");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !q_valid))
    else $error("registers not empty after reset");

endmodule
`default_nettype wire
